// File: rtl/gasa_pkg.sv
`default_nettype none
package gasa_pkg;

    localparam int CACHE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

    localparam int KEY_W   = 16;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CUR_W   = 14;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

    typedef enum logic [0:0] {
        OP_PLACE = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STAT_HIT     = 3'd0,
        STAT_PLACED  = 3'd1,
        STAT_BLANK   = 3'd2,
        STAT_NOSPACE = 3'd3,
        STAT_FULL    = 3'd4,
        STAT_CLEARED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRAP,
        S_PLACE
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_CLEAR,
        SH_WRAP,
        SH_PLACE
    } shelf_cmd_t;

    typedef struct packed {
        op_t                        opcode;
        logic [KEY_W-1:0]           glyph_code;
        logic                       bitmap_present;
        logic [COORD_W-1:0]         bitmap_width;
        logic [COORD_W-1:0]         bitmap_height;
        logic signed [COORD_W-1:0]  offset_x;
        logic signed [COORD_W-1:0]  offset_y;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic [COORD_W-1:0]         rect_x;
        logic [COORD_W-1:0]         rect_y;
        logic [COORD_W-1:0]         rect_w;
        logic [COORD_W-1:0]         rect_h;
        logic signed [COORD_W-1:0]  out_offset_x;
        logic signed [COORD_W-1:0]  out_offset_y;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   glyph_key;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_w;
        logic [COORD_W-1:0] rect_h;
        logic [COORD_W-1:0] offset_x;
        logic [COORD_W-1:0] offset_y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

    typedef struct packed {
        logic [CUR_W-1:0] column;
        logic [CUR_W-1:0] row;
        logic             nospace;
    } shelf_stat_t;

endpackage
`default_nettype wire

// File: rtl/gasa_ram.sv
`default_nettype none
module gasa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/gasa_scan.sv
`default_nettype none
module gasa_scan (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [gasa_pkg::KEY_W-1:0] key,
    input  wire logic [gasa_pkg::CNT_W-1:0] count,
    input  wire logic [gasa_pkg::KEY_W-1:0] rd_key,
    output logic      [gasa_pkg::IDX_W-1:0] rd_addr,
    output gasa_pkg::scan_stat_t            stat
);
    import gasa_pkg::*;

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             match;
    logic             more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            idx_reg  <= idx_next;
        end
    end

    // compare the row read last cycle while the next one is fetched
    assign match   = pend_reg && (rd_key == key);
    assign more    = idx_reg < count;
    assign rd_addr = idx_reg[IDX_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        idx_next  = idx_reg;
        stat      = '0;
        if (start)
        begin
            busy_next = 1'b1;
            pend_next = 1'b0;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (match)
            begin
                stat.done = 1'b1;
                stat.hit  = 1'b1;
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
            else if (more)
            begin
                idx_next  = idx_reg + CNT_W'(1);
                pend_next = 1'b1;
            end
            else
            begin
                stat.done = 1'b1;
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/gasa_shelf.sv
`default_nettype none
module gasa_shelf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gasa_pkg::shelf_cmd_t          cmd,
    input  wire logic [gasa_pkg::COORD_W-1:0]  bitmap_width,
    input  wire logic [gasa_pkg::COORD_W-1:0]  bitmap_height,
    input  wire logic [gasa_pkg::DIM_W-1:0]    atlas_width,
    input  wire logic [gasa_pkg::DIM_W-1:0]    atlas_height,
    output gasa_pkg::shelf_stat_t              stat
);
    import gasa_pkg::*;

    logic [CUR_W-1:0] col_reg, col_next;
    logic [CUR_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] sh_reg, sh_next;
    logic [DIM_W-1:0] gw;
    logic [DIM_W-1:0] gh;
    logic [CUR_W:0]   col_end;
    logic [CUR_W:0]   row_end;
    logic [CUR_W:0]   row_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            sh_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            sh_reg  <= sh_next;
        end
    end

    // padded glyph: one pixel right and below
    assign gw       = {1'b0, bitmap_width} + DIM_W'(1);
    assign gh       = {1'b0, bitmap_height} + DIM_W'(1);
    assign col_end  = {1'b0, col_reg} + {2'b0, gw};
    assign row_end  = {1'b0, row_reg} + {2'b0, gh};
    assign row_open = {1'b0, row_reg} + {2'b0, sh_reg};

    assign stat.column  = col_reg;
    assign stat.row     = row_reg;
    assign stat.nospace = (gw > atlas_width) || (row_end > {2'b0, atlas_height});

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        sh_next  = sh_reg;
        unique case (cmd)
            SH_NONE:
            begin
            end
            SH_CLEAR:
            begin
                col_next = '0;
                row_next = '0;
                sh_next  = '0;
            end
            SH_WRAP:
            begin
                // open a new shelf when the rest of this one is too narrow
                if (col_end > {2'b0, atlas_width})
                begin
                    col_next = '0;
                    row_next = row_open[CUR_W-1:0];
                    sh_next  = '0;
                end
            end
            SH_PLACE:
            begin
                col_next = col_end[CUR_W-1:0];
                if (gh > sh_reg)
                begin
                    sh_next = gh;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/glyph_atlas_shelf_allocator_top.sv
// Glyph atlas shelf allocator. Pulse start with an item while busy is low; the
// single result appears on result for exactly one cycle with done high and must
// be taken then, as there is no way to hold it. A clear returns its result in
// the next cycle. A place request scans the glyph cache one entry a cycle
// through the cache memory's single read port, and a new placement then passes
// through the wrap and place states; busy stays high throughout. atlas_width and
// atlas_height are written through the cfg channel, which is ready only while
// busy is low.
`default_nettype none
module glyph_atlas_shelf_allocator_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire gasa_pkg::in_item_t               item,
    output logic                                  busy,
    output logic                                  done,
    output gasa_pkg::result_t                     result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gasa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gasa_pkg::DIM_W-1:0]       cfg_data
);
    import gasa_pkg::*;

    state_t           state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0] aw_reg;
    logic [DIM_W-1:0] ah_reg;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             accept;
    logic             scan_start;
    scan_stat_t       scan_stat;
    shelf_cmd_t       shelf_cmd;
    shelf_stat_t      shelf_stat;
    logic [IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    entry_t           rd_entry;
    logic             wr_en;
    entry_t           wr_entry;
    logic             blank;
    logic             full;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = !busy;
    assign rd_entry  = entry_t'(rd_raw);

    assign blank = !item_reg.bitmap_present || (item_reg.bitmap_width == '0)
                   || (item_reg.bitmap_height == '0);
    assign full  = (count_reg == CNT_W'(CACHE_ENTRIES));

    gasa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    gasa_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .key     (item_reg.glyph_code),
        .count   (count_reg),
        .rd_key  (rd_entry.glyph_key),
        .rd_addr (rd_addr),
        .stat    (scan_stat)
    );

    gasa_shelf u_shelf (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (shelf_cmd),
        .bitmap_width  (item_reg.bitmap_width),
        .bitmap_height (item_reg.bitmap_height),
        .atlas_width   (aw_reg),
        .atlas_height  (ah_reg),
        .stat          (shelf_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            aw_reg    <= ATLAS_RESET;
            ah_reg    <= ATLAS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ATLAS_WIDTH:  aw_reg <= cfg_data;
                    CFG_ATLAS_HEIGHT: ah_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        scan_start  = 1'b0;
        shelf_cmd   = SH_NONE;
        wr_en       = 1'b0;
        wr_entry    = '0;
        wr_entry.glyph_key = item_reg.glyph_code;
        wr_entry.offset_x  = item_reg.offset_x;
        wr_entry.offset_y  = item_reg.offset_y;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                    if (item.opcode == OP_CLEAR)
                    begin
                        shelf_cmd          = SH_CLEAR;
                        count_next         = '0;
                        done_next          = 1'b1;
                        result_next        = '0;
                        result_next.status = STAT_CLEARED;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (scan_stat.hit)
                    begin
                        result_next.status       = STAT_HIT;
                        result_next.rect_x       = rd_entry.rect_x;
                        result_next.rect_y       = rd_entry.rect_y;
                        result_next.rect_w       = rd_entry.rect_w;
                        result_next.rect_h       = rd_entry.rect_h;
                        result_next.out_offset_x = rd_entry.offset_x;
                        result_next.out_offset_y = rd_entry.offset_y;
                    end
                    else if (full)
                    begin
                        result_next        = '0;
                        result_next.status = STAT_FULL;
                    end
                    else if (blank)
                    begin
                        wr_en       = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        result_next = '0;
                        result_next.status       = STAT_BLANK;
                        result_next.out_offset_x = item_reg.offset_x;
                        result_next.out_offset_y = item_reg.offset_y;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP:
            begin
                shelf_cmd  = SH_WRAP;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (shelf_stat.nospace)
                begin
                    result_next        = '0;
                    result_next.status = STAT_NOSPACE;
                end
                else
                begin
                    shelf_cmd       = SH_PLACE;
                    wr_en           = 1'b1;
                    wr_entry.rect_x = shelf_stat.column[COORD_W-1:0];
                    wr_entry.rect_y = shelf_stat.row[COORD_W-1:0];
                    wr_entry.rect_w = item_reg.bitmap_width;
                    wr_entry.rect_h = item_reg.bitmap_height;
                    count_next      = count_reg + CNT_W'(1);
                    result_next.status       = STAT_PLACED;
                    result_next.rect_x       = shelf_stat.column[COORD_W-1:0];
                    result_next.rect_y       = shelf_stat.row[COORD_W-1:0];
                    result_next.rect_w       = item_reg.bitmap_width;
                    result_next.rect_h       = item_reg.bitmap_height;
                    result_next.out_offset_x = item_reg.offset_x;
                    result_next.out_offset_y = item_reg.offset_y;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/gasa_checker.sv
`default_nettype none
module gasa_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire gasa_pkg::in_item_t              item,
    input  wire logic                            busy,
    input  wire logic                            done,
    input  wire gasa_pkg::result_t               result,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready
);
    import gasa_pkg::*;

    // a result only ever appears as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_clear_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.opcode == OP_CLEAR
        |=> done && result.status == STAT_CLEARED && !busy)
        else $error("clear did not complete in one cycle");

    a_place_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.opcode == OP_PLACE |=> busy && !done)
        else $error("place request did not start a search");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STAT_FULL || result.status == STAT_NOSPACE)
        |-> result.rect_x == '0 && result.rect_y == '0 && result.rect_w == '0
            && result.rect_h == '0 && result.out_offset_x == '0
            && result.out_offset_y == '0)
        else $error("failed placement carries a non-zero rectangle");

    // settings change only between items
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !busy)
        else $error("configuration transfer while an item is in flight");

endmodule

bind glyph_atlas_shelf_allocator_top gasa_checker u_gasa_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gasa_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int NUM_PHASES      = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    in_item_t             item      = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    result_t              result;
    logic                 cfg_ready;

    glyph_atlas_shelf_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Allocator state as the testbench sees it
    int      atlas_w = int'(ATLAS_RESET);
    int      atlas_h = int'(ATLAS_RESET);
    logic [KEY_W-1:0] glyph_keys [CACHE_ENTRIES];
    result_t glyph_rects [CACHE_ENTRIES];
    int      glyphs_cached = 0;
    int      shelf_col = 0;
    int      shelf_row = 0;
    int      shelf_h = 0;

    result_t pending_rects [$];
    result_t oldest_rect;
    int      errors = 0;
    int      cycles = 0;
    int      requests_sent = 0;
    int      settings_used = 0;
    int      status_seen [8];
    int      burst_left = 0;

    int      phase_w [NUM_PHASES] = '{1024, 4096, 64, 8191, 1, 0, -1, 200};
    int      phase_h [NUM_PHASES] = '{1024, 4096, 48, 8191, 1, 0, -1, 4096};
    int      phase_clear [NUM_PHASES] = '{0, 0, 0, 0, 40, 40, 60, 80};

    typedef struct {
        in_item_t stim;
        bit       typed;
        result_t  golden;
    } dir_row_t;

    dir_row_t dir_tab [$];

    function automatic result_t predict_glyph_request(in_item_t it);
        result_t r;
        int      i;
        int      gw;
        int      gh;
        bit      found;
        r = '0;
        found = 1'b0;
        if (it.opcode == OP_CLEAR)
        begin
            glyphs_cached = 0;
            shelf_col = 0;
            shelf_row = 0;
            shelf_h = 0;
            r.status = STAT_CLEARED;
            return r;
        end
        for (i = 0; i < glyphs_cached; i++)
        begin
            if (!found && glyph_keys[i] == it.glyph_code)
            begin
                found = 1'b1;
                r = glyph_rects[i];
                r.status = STAT_HIT;
            end
        end
        if (found)
            return r;
        if (glyphs_cached >= CACHE_ENTRIES)
        begin
            r.status = STAT_FULL;
            return r;
        end
        r.out_offset_x = it.offset_x;
        r.out_offset_y = it.offset_y;
        if (!it.bitmap_present || it.bitmap_width == '0 || it.bitmap_height == '0)
        begin
            r.status = STAT_BLANK;
        end
        else
        begin
            gw = int'(it.bitmap_width) + 1;
            gh = int'(it.bitmap_height) + 1;
            // open a new shelf first; the move holds even if the glyph then fails
            if (shelf_col + gw > atlas_w)
            begin
                shelf_col = 0;
                shelf_row = (shelf_row + shelf_h) & 'h3FFF;
                shelf_h = 0;
            end
            if (gw > atlas_w || shelf_row + gh > atlas_h)
            begin
                r = '0;
                r.status = STAT_NOSPACE;
                return r;
            end
            r.status = STAT_PLACED;
            r.rect_x = 12'(shelf_col);
            r.rect_y = 12'(shelf_row);
            r.rect_w = it.bitmap_width;
            r.rect_h = it.bitmap_height;
            shelf_col = (shelf_col + gw) & 'h3FFF;
            if (gh > shelf_h)
                shelf_h = gh & 'h1FFF;
        end
        glyph_keys[glyphs_cached] = it.glyph_code;
        glyph_rects[glyphs_cached] = r;
        glyphs_cached++;
        return r;
    endfunction

    function automatic in_item_t mk_item(op_t op, int id, bit pres, int w, int h,
                                         int bx, int by);
        in_item_t it;
        it.opcode = op;
        it.glyph_code = 16'(id);
        it.bitmap_present = pres;
        it.bitmap_width = 12'(w);
        it.bitmap_height = 12'(h);
        it.offset_x = 12'(bx);
        it.offset_y = 12'(by);
        return it;
    endfunction

    function automatic result_t mk_result(status_t st, int x, int y, int w, int h,
                                          int bx, int by);
        result_t r;
        r.status = st;
        r.rect_x = 12'(x);
        r.rect_y = 12'(y);
        r.rect_w = 12'(w);
        r.rect_h = 12'(h);
        r.out_offset_x = 12'(bx);
        r.out_offset_y = 12'(by);
        return r;
    endfunction

    function automatic in_item_t random_request(int clear_odds);
        in_item_t    it;
        logic [95:0] raw;
        int          pick;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        if (clear_odds != 0 && $urandom_range(clear_odds - 1, 0) == 0)
        begin
            it.opcode = OP_CLEAR;
            return it;
        end
        it.opcode = OP_PLACE;
        // mostly a small id pool so that repeats hit the cache
        if ($urandom_range(99, 0) < 85)
            it.glyph_code = 16'($urandom_range(511, 0));
        it.bitmap_present = ($urandom_range(9, 0) != 0);
        pick = $urandom_range(99, 0);
        if (pick < 75)
        begin
            it.bitmap_width = 12'($urandom_range(16, 1));
            it.bitmap_height = 12'($urandom_range(16, 1));
        end
        else if (pick < 90)
        begin
            it.bitmap_width = 12'($urandom_range(255, 0));
            it.bitmap_height = 12'($urandom_range(255, 0));
        end
        else if (pick < 93)
        begin
            it.bitmap_width = '0;
        end
        return it;
    endfunction

    task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Results cannot be held off: take each one on the cycle it is strobed
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rects.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, got %p",
                         $time, result);
                errors++;
            end
            else
            begin
                oldest_rect = pending_rects.pop_front();
                check_field("status", 12'(oldest_rect.status), 12'(result.status));
                check_field("rect_x", oldest_rect.rect_x, result.rect_x);
                check_field("rect_y", oldest_rect.rect_y, result.rect_y);
                check_field("rect_w", oldest_rect.rect_w, result.rect_w);
                check_field("rect_h", oldest_rect.rect_h, result.rect_h);
                check_field("out_offset_x", oldest_rect.out_offset_x,
                            result.out_offset_x);
                check_field("out_offset_y", oldest_rect.out_offset_y,
                            result.out_offset_y);
                status_seen[int'(oldest_rect.status)]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("glyph_atlas_shelf_allocator_top test failed");
            $finish;
        end
    end

    // Hold start and the item until the transfer completes
    task automatic send_request(in_item_t it);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        requests_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        start <= 1'b0;
        gap = $urandom_range(99, 0);
        if (gap < 70)
            gap = $urandom_range(6, 1);
        else if (gap < 90)
            gap = $urandom_range(80, 7);
        else
            gap = $urandom_range(300, 81);
        repeat (gap) @(posedge clk);
        if ($urandom_range(4, 0) == 0)
            burst_left = $urandom_range(60, 30);
        else
            burst_left = $urandom_range(16, 0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_ATLAS_WIDTH)
            atlas_w = int'(val);
        else
            atlas_h = int'(val);
    endtask

    task automatic set_atlas(int w, int h);
        write_reg(CFG_ATLAS_WIDTH, DIM_W'(w));
        write_reg(CFG_ATLAS_HEIGHT, DIM_W'(h));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int       p;
        int       n;
        int       w;
        int       h;
        in_item_t it;
        result_t  predicted;

        // at the reset setting, cache empty, cursor at the origin
        dir_tab.push_back('{mk_item(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1,
                            mk_result(STAT_CLEARED, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_item(OP_PLACE, 0, 1, 10, 20, -2048, 2047), 1'b1,
                            mk_result(STAT_PLACED, 0, 0, 10, 20, -2048, 2047)});
        dir_tab.push_back('{mk_item(OP_PLACE, 0, 0, 4095, 4095, 1, 1), 1'b1,
                            mk_result(STAT_HIT, 0, 0, 10, 20, -2048, 2047)});
        dir_tab.push_back('{mk_item(OP_PLACE, 'hFFFF, 0, 4095, 4095, 2047, -2048), 1'b1,
                            mk_result(STAT_BLANK, 0, 0, 0, 0, 2047, -2048)});
        dir_tab.push_back('{mk_item(OP_PLACE, 1, 1, 0, 7, 5, -5), 1'b1,
                            mk_result(STAT_BLANK, 0, 0, 0, 0, 5, -5)});
        dir_tab.push_back('{mk_item(OP_PLACE, 2, 1, 9, 0, -1, 0), 1'b1,
                            mk_result(STAT_BLANK, 0, 0, 0, 0, -1, 0)});
        dir_tab.push_back('{mk_item(OP_PLACE, 'hFFFF, 1, 3, 3, 0, 0), 1'b1,
                            mk_result(STAT_HIT, 0, 0, 0, 0, 2047, -2048)});
        dir_tab.push_back('{mk_item(OP_PLACE, 3, 1, 4095, 1, 7, 7), 1'b1,
                            mk_result(STAT_NOSPACE, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_item(OP_PLACE, 4, 1, 1000, 3, 12, -12), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 5, 1, 100, 50, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 6, 1, 1, 4095, 3, 3), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 7, 1, 1023, 998, -7, 9), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 8, 1, 1, 1, 'h555, 'hAAA), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 'hAAAA, 1, 'hAAA, 'h555, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_PLACE, 'h5555, 1, 'h555, 'h2AA, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_item(OP_CLEAR, 'hFFFF, 1, 4095, 4095, -1, -1), 1'b1,
                            mk_result(STAT_CLEARED, 0, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_item(OP_PLACE, 0, 1, 10, 20, 0, 0), 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            send_request(dir_tab[k].stim);
            predicted = predict_glyph_request(dir_tab[k].stim);
            pending_rects.push_back(dir_tab[k].typed ? dir_tab[k].golden : predicted);
            pace_sender();
        end

        // early phases never clear, so the cache fills up along the way
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            w = (phase_w[p] < 0) ? $urandom_range(4096, 1) : phase_w[p];
            h = (phase_h[p] < 0) ? $urandom_range(4096, 1) : phase_h[p];
            set_atlas(w, h);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it = random_request(phase_clear[p]);
                send_request(it);
                pending_rects.push_back(predict_glyph_request(it));
                pace_sender();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests over %0d atlas settings in %0d cycles.",
                 requests_sent, settings_used, cycles);
        $display("Outcomes: hit %0d, placed %0d, blank %0d, no space %0d, full %0d, clear %0d",
                 status_seen[STAT_HIT], status_seen[STAT_PLACED], status_seen[STAT_BLANK],
                 status_seen[STAT_NOSPACE], status_seen[STAT_FULL],
                 status_seen[STAT_CLEARED]);
        if (errors == 0)
            $display("glyph_atlas_shelf_allocator_top test passed");
        else
            $display("glyph_atlas_shelf_allocator_top test failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/gasa_pkg.sv
rtl/gasa_ram.sv
rtl/gasa_scan.sv
rtl/gasa_shelf.sv
rtl/glyph_atlas_shelf_allocator_top.sv
rtl/gasa_checker.sv
sim/testbench.sv
